[design/npx_pkg.sv]
// Shared types and constants for the value-noise height pixel block.
`timescale 1ns / 1ps
package npx_pkg;

   localparam int SUM_W = 24;

   typedef logic signed [SUM_W-1:0] sum_type;
   typedef logic signed [17:0] corner_type;
   typedef logic [16:0] weight_type;
   typedef logic [15:0] amp_type;

   typedef struct packed {
      logic [12:0] map_width;
      logic [12:0] map_height;
      logic [12:0] zoom_divisor;
      logic [15:0] persistence;
      logic [2:0]  octave_count;
      logic [31:0] seed_offset;
      logic        island_mode;
   } cfg_type;

   // register indexes (byte address is 4 times the index)
   localparam logic [2:0] REG_MAP_WIDTH    = 3'd0;
   localparam logic [2:0] REG_MAP_HEIGHT   = 3'd1;
   localparam logic [2:0] REG_ZOOM_DIVISOR = 3'd2;
   localparam logic [2:0] REG_PERSISTENCE  = 3'd3;
   localparam logic [2:0] REG_OCTAVE_COUNT = 3'd4;
   localparam logic [2:0] REG_SEED_OFFSET  = 3'd5;
   localparam logic [2:0] REG_ISLAND_MODE  = 3'd6;

   localparam logic [12:0] RST_MAP_WIDTH    = 13'd256;
   localparam logic [12:0] RST_MAP_HEIGHT   = 13'd256;
   localparam logic [12:0] RST_ZOOM_DIVISOR = 13'd64;
   localparam logic [15:0] RST_PERSISTENCE  = 16'd32768;
   localparam logic [2:0]  RST_OCTAVE_COUNT = 3'd3;
   localparam logic [31:0] RST_SEED_OFFSET  = 32'd0;
   localparam logic        RST_ISLAND_MODE  = 1'b0;

   localparam logic [31:0] HASH_ROW_MUL = 32'd57;
   localparam logic [31:0] HASH_MUL_A   = 32'd60493;
   localparam logic [31:0] HASH_ADD_A   = 32'd19990303;
   localparam logic [31:0] HASH_ADD_B   = 32'd1376312589;

   localparam logic [16:0] UNITY = 17'd65536;

   localparam sum_type BIAS_START = 24'sd19661;
   localparam sum_type BIAS_MIN   = -24'sd1048576;
   localparam sum_type SUM_MAX    = 24'sd1048575;
   localparam sum_type SUM_MIN    = -24'sd1048576;
   localparam sum_type OUT_OFFSET = 24'sd65536;

   localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

endpackage

[design/value_noise_height_pixel.sv]
// Top level: fractal value-noise height for one pixel per clock.
//
// Input channel: start with req_pixel_x / req_pixel_y; an item is taken
// on every edge where start is high and busy is low. busy stays low, so a
// new pixel can enter on every clock.
// Result channel: rsp_valid strobes for one cycle with rsp_height_value;
// results leave in the order the pixels came in. The receiver cannot stall.
// Pipeline: front registers, then the pipelined long dividers
// (coordinate / zoom and the island falloff quotients), DIV_W bits
// wide with one quotient bit per stage, then one cell per octave; each
// octave cell adds seven stages of hash multiplies and blends.
// Throughput: one item per clock.
// Configuration: APB registers at byte offsets 0x00..0x18, writes take
// effect at once, also for items already in the pipeline.
// Reset: registers return to their defaults and all in-flight items are
// dropped; no clearing pass is needed.
`timescale 1ns / 1ps
module value_noise_height_pixel import npx_pkg::*; #(
   parameter int MAX_OCTAVES     = 8,
   parameter int COORD_BITS      = 12,
   parameter int COS_TABLE_DEPTH = 256
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic [COORD_BITS-1:0] req_pixel_x,
   input  logic [COORD_BITS-1:0] req_pixel_y,
   output logic                  rsp_valid,
   output logic [7:0]            rsp_height_value,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [4:0]            paddr,
   input  logic [31:0]           pwdata,
   output logic [31:0]           prdata,
   output logic                  pready
);

   localparam int Q_W   = COORD_BITS + 16 + MAX_OCTAVES - 1;
   localparam int E_W   = (COORD_BITS + 3 > 15) ? COORD_BITS + 3 : 15;
   localparam int PEN_W = 2 * E_W + 15;
   localparam int DIV_W = (PEN_W > Q_W) ? PEN_W : Q_W;
   localparam int VLD_N = 3 + DIV_W;

   localparam logic [DIV_W-1:0] PEN_CAP = DIV_W'(64'd2097152);

   // ---------------- configuration registers ----------------
   cfg_type cfg_ff;
   logic    csr_wr;

   assign csr_wr = psel & penable & pwrite;
   assign pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.map_width    <= RST_MAP_WIDTH;
         cfg_ff.map_height   <= RST_MAP_HEIGHT;
         cfg_ff.zoom_divisor <= RST_ZOOM_DIVISOR;
         cfg_ff.persistence  <= RST_PERSISTENCE;
         cfg_ff.octave_count <= RST_OCTAVE_COUNT;
         cfg_ff.seed_offset  <= RST_SEED_OFFSET;
         cfg_ff.island_mode  <= RST_ISLAND_MODE;
      end else if (csr_wr) begin
         case (paddr[4:2])
            REG_MAP_WIDTH:    cfg_ff.map_width    <= pwdata[12:0];
            REG_MAP_HEIGHT:   cfg_ff.map_height   <= pwdata[12:0];
            REG_ZOOM_DIVISOR: cfg_ff.zoom_divisor <= pwdata[12:0];
            REG_PERSISTENCE:  cfg_ff.persistence  <= pwdata[15:0];
            REG_OCTAVE_COUNT: cfg_ff.octave_count <= pwdata[2:0];
            REG_SEED_OFFSET:  cfg_ff.seed_offset  <= pwdata;
            REG_ISLAND_MODE:  cfg_ff.island_mode  <= pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (paddr[4:2])
         REG_MAP_WIDTH:    prdata = 32'(cfg_ff.map_width);
         REG_MAP_HEIGHT:   prdata = 32'(cfg_ff.map_height);
         REG_ZOOM_DIVISOR: prdata = 32'(cfg_ff.zoom_divisor);
         REG_PERSISTENCE:  prdata = 32'(cfg_ff.persistence);
         REG_OCTAVE_COUNT: prdata = 32'(cfg_ff.octave_count);
         REG_SEED_OFFSET:  prdata = cfg_ff.seed_offset;
         REG_ISLAND_MODE:  prdata = 32'(cfg_ff.island_mode);
         default:          prdata = '0;
      endcase
   end

   // zero sizes and divisor act as one
   logic [12:0] zoom_eff;
   logic [12:0] mw_eff;
   logic [12:0] mh_eff;
   logic [25:0] sx2_ff;
   logic [25:0] sy2_ff;

   assign zoom_eff = (cfg_ff.zoom_divisor == '0) ? 13'd1 : cfg_ff.zoom_divisor;
   assign mw_eff   = (cfg_ff.map_width == '0) ? 13'd1 : cfg_ff.map_width;
   assign mh_eff   = (cfg_ff.map_height == '0) ? 13'd1 : cfg_ff.map_height;

   always_ff @(posedge clock) begin
      sx2_ff <= 26'(mw_eff) * 26'(mw_eff);
      sy2_ff <= 26'(mh_eff) * 26'(mh_eff);
   end

   // distance past the 0.4..0.6 band, times five
   function automatic logic [E_W-1:0] edge_dist(logic [COORD_BITS-1:0] c, logic [12:0] s);
      logic [E_W-1:0] c5;
      logic [E_W-1:0] s3;
      logic [E_W-1:0] s2;
      c5 = E_W'(c) * E_W'(5);
      s3 = E_W'(s) * E_W'(3);
      s2 = E_W'(s) << 1;
      if (c5 > s3) return c5 - s3;
      else if (c5 < s2) return s2 - c5;
      else return '0;
   endfunction

   // ---------------- front pipeline ----------------
   logic                  accept;
   logic                  vld_ff [VLD_N];
   logic [COORD_BITS-1:0] px0_ff, py0_ff, px1_ff, py1_ff, px2_ff, py2_ff;
   logic [E_W-1:0]        ex1_ff, ey1_ff;
   logic [2*E_W-1:0]      ex2_ff, ey2_ff;

   assign busy   = 1'b0;
   assign accept = start & ~busy;

   always_ff @(posedge clock) begin
      px0_ff <= req_pixel_x;
      py0_ff <= req_pixel_y;
      px1_ff <= px0_ff;
      py1_ff <= py0_ff;
      ex1_ff <= edge_dist(px0_ff, mw_eff);
      ey1_ff <= edge_dist(py0_ff, mh_eff);
      px2_ff <= px1_ff;
      py2_ff <= py1_ff;
      ex2_ff <= (2*E_W)'(ex1_ff) * (2*E_W)'(ex1_ff);
      ey2_ff <= (2*E_W)'(ey1_ff) * (2*E_W)'(ey1_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < VLD_N; k++) vld_ff[k] <= 1'b0;
      end else begin
         vld_ff[0] <= accept;
         for (int k = 1; k < VLD_N; k++) vld_ff[k] <= vld_ff[k-1];
      end
   end

   logic [DIV_W-1:0] coord_num_x, coord_num_y, pen_num_x, pen_num_y;
   logic [DIV_W-1:0] quo_x, quo_y, quo_pen_x, quo_pen_y;

   assign coord_num_x = DIV_W'(px2_ff) << (Q_W - COORD_BITS);
   assign coord_num_y = DIV_W'(py2_ff) << (Q_W - COORD_BITS);
   // 3*e^2*65536 / (8*S^2) == 3*e^2*8192 / S^2
   assign pen_num_x = DIV_W'(PEN_W'(PEN_W'(ex2_ff) * PEN_W'(3)) << 13);
   assign pen_num_y = DIV_W'(PEN_W'(PEN_W'(ey2_ff) * PEN_W'(3)) << 13);

   npx_divider #(.NUM_W(DIV_W), .DEN_W(13)) u_div_x (
      .clock(clock), .num(coord_num_x), .den(zoom_eff), .quo(quo_x));
   npx_divider #(.NUM_W(DIV_W), .DEN_W(13)) u_div_y (
      .clock(clock), .num(coord_num_y), .den(zoom_eff), .quo(quo_y));
   npx_divider #(.NUM_W(DIV_W), .DEN_W(26)) u_pen_x (
      .clock(clock), .num(pen_num_x), .den(sx2_ff), .quo(quo_pen_x));
   npx_divider #(.NUM_W(DIV_W), .DEN_W(26)) u_pen_y (
      .clock(clock), .num(pen_num_y), .den(sy2_ff), .quo(quo_pen_y));

   // ---------------- island bias ----------------
   logic [21:0]    pen_x_sat, pen_y_sat;
   sum_type        bias_raw;
   logic           vb_ff;
   sum_type        bias_ff;
   logic [Q_W-1:0] qx_b_ff, qy_b_ff;

   assign pen_x_sat = (quo_pen_x >= PEN_CAP) ? PEN_CAP[21:0] : quo_pen_x[21:0];
   assign pen_y_sat = (quo_pen_y >= PEN_CAP) ? PEN_CAP[21:0] : quo_pen_y[21:0];
   assign bias_raw  = BIAS_START - sum_type'({2'b00, pen_x_sat})
                                 - sum_type'({2'b00, pen_y_sat});

   always_ff @(posedge clock) begin
      qx_b_ff <= quo_x[Q_W-1:0];
      qy_b_ff <= quo_y[Q_W-1:0];
      if (!cfg_ff.island_mode) bias_ff <= '0;
      else if (bias_raw < BIAS_MIN) bias_ff <= BIAS_MIN;
      else bias_ff <= bias_raw;
   end

   always_ff @(posedge clock) begin
      if (reset) vb_ff <= 1'b0;
      else vb_ff <= vld_ff[VLD_N-1];
   end

   // ---------------- octave cells ----------------
   logic           ch_valid [MAX_OCTAVES+1];
   logic [Q_W-1:0] ch_qx    [MAX_OCTAVES];
   logic [Q_W-1:0] ch_qy    [MAX_OCTAVES];
   sum_type        ch_sum   [MAX_OCTAVES+1];
   amp_type        ch_amp   [MAX_OCTAVES];

   assign ch_valid[0] = vb_ff;
   assign ch_qx[0]    = qx_b_ff;
   assign ch_qy[0]    = qy_b_ff;
   assign ch_sum[0]   = bias_ff;
   assign ch_amp[0]   = cfg_ff.persistence;

   for (genvar a = 0; a < MAX_OCTAVES; a++) begin : g_cell
      if (a < MAX_OCTAVES - 1) begin : g_mid
         npx_cell #(
            .OCT(a), .MAX_OCTAVES(MAX_OCTAVES), .COORD_BITS(COORD_BITS),
            .COS_TABLE_DEPTH(COS_TABLE_DEPTH)
         ) u_cell (
            .clock(clock), .reset(reset), .cfg(cfg_ff),
            .up_valid(ch_valid[a]), .up_qx(ch_qx[a]), .up_qy(ch_qy[a]),
            .up_sum(ch_sum[a]), .up_amp(ch_amp[a]),
            .dn_valid(ch_valid[a+1]), .dn_qx(ch_qx[a+1]), .dn_qy(ch_qy[a+1]),
            .dn_sum(ch_sum[a+1]), .dn_amp(ch_amp[a+1]));
      end else begin : g_last
         npx_cell #(
            .OCT(a), .MAX_OCTAVES(MAX_OCTAVES), .COORD_BITS(COORD_BITS),
            .COS_TABLE_DEPTH(COS_TABLE_DEPTH)
         ) u_cell (
            .clock(clock), .reset(reset), .cfg(cfg_ff),
            .up_valid(ch_valid[a]), .up_qx(ch_qx[a]), .up_qy(ch_qy[a]),
            .up_sum(ch_sum[a]), .up_amp(ch_amp[a]),
            .dn_valid(ch_valid[a+1]), .dn_qx(), .dn_qy(),
            .dn_sum(ch_sum[a+1]), .dn_amp());
      end
   end

   // ---------------- output ----------------
   sum_type sum_end;
   sum_type sum_clamped;
   sum_type shifted;
   logic [7:0] height_in;

   assign sum_end = ch_sum[MAX_OCTAVES];

   always_comb begin
      if (sum_end > SUM_MAX) sum_clamped = SUM_MAX;
      else if (sum_end < SUM_MIN) sum_clamped = SUM_MIN;
      else sum_clamped = sum_end;
      // (sum*128 + 128*65536) >> 16 == (sum + 65536) >> 9
      shifted = sum_clamped + OUT_OFFSET;
      if (shifted < 0) height_in = 8'd0;
      else if (shifted[SUM_W-1:17] != '0) height_in = 8'd255;
      else height_in = shifted[16:9];
   end

   always_ff @(posedge clock) begin
      rsp_height_value <= height_in;
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_valid <= 1'b0;
      else rsp_valid <= ch_valid[MAX_OCTAVES];
   end

endmodule

[design/npx_divider.sv]
// Pipelined restoring divider, one quotient bit per stage.
`timescale 1ns / 1ps
module npx_divider #(
   parameter int NUM_W = 48,
   parameter int DEN_W = 13
) (
   input  logic             clock,
   input  logic [NUM_W-1:0] num,
   input  logic [DEN_W-1:0] den,
   output logic [NUM_W-1:0] quo
);

   logic [DEN_W-1:0] rem_ff [NUM_W];
   logic [NUM_W-1:0] num_ff [NUM_W];

   for (genvar i = 0; i < NUM_W; i++) begin : g_stage
      logic [DEN_W-1:0] rem_prev;
      logic [NUM_W-1:0] num_prev;
      logic [DEN_W:0]   trial;
      logic [DEN_W-1:0] rem_in;
      logic [NUM_W-1:0] num_in;

      if (i == 0) begin : g_first
         assign rem_prev = '0;
         assign num_prev = num;
      end else begin : g_next
         assign rem_prev = rem_ff[i-1];
         assign num_prev = num_ff[i-1];
      end

      // dividend shifts out at the top, quotient bits shift in at the bottom
      assign trial = {rem_prev, num_prev[NUM_W-1]};

      always_comb begin
         if (trial >= {1'b0, den}) begin
            rem_in = DEN_W'(trial - {1'b0, den});
            num_in = {num_prev[NUM_W-2:0], 1'b1};
         end else begin
            rem_in = trial[DEN_W-1:0];
            num_in = {num_prev[NUM_W-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         rem_ff[i] <= rem_in;
         num_ff[i] <= num_in;
      end
   end

   assign quo = num_ff[NUM_W-1];

endmodule

[design/npx_cell.sv]
// One octave cell: lattice hash, cosine blend and amplitude add, seven stages.
`timescale 1ns / 1ps
module npx_cell import npx_pkg::*; #(
   parameter int OCT             = 0,
   parameter int MAX_OCTAVES     = 8,
   parameter int COORD_BITS      = 12,
   parameter int COS_TABLE_DEPTH = 256
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  cfg_type                              cfg,
   input  logic                                 up_valid,
   input  logic [COORD_BITS+16+MAX_OCTAVES-2:0] up_qx,
   input  logic [COORD_BITS+16+MAX_OCTAVES-2:0] up_qy,
   input  sum_type                              up_sum,
   input  amp_type                              up_amp,
   output logic                                 dn_valid,
   output logic [COORD_BITS+16+MAX_OCTAVES-2:0] dn_qx,
   output logic [COORD_BITS+16+MAX_OCTAVES-2:0] dn_qy,
   output sum_type                              dn_sum,
   output amp_type                              dn_amp
);

   localparam int Q_W    = COORD_BITS + 16 + MAX_OCTAVES - 1;
   localparam int TBL_W  = $clog2(COS_TABLE_DEPTH);
   localparam int SHIFT  = MAX_OCTAVES - 1 - OCT;
   localparam int STAGES = 7;

   // (1 - cos)/2 in Q0.16 from a Taylor sine, squared
   function automatic weight_type cos_weight(int unsigned i);
      longint unsigned ang;
      longint unsigned sq;
      longint unsigned term;
      longint unsigned ss;
      longint          s;
      ang  = (HALF_PI_Q30 * longint'(i)) / COS_TABLE_DEPTH;
      sq   = (ang * ang) >> 30;
      s    = longint'(ang);
      term = ((ang * sq) >> 30) / 6;
      s    = s - longint'(term);
      term = ((term * sq) >> 30) / 20;
      s    = s + longint'(term);
      term = ((term * sq) >> 30) / 42;
      s    = s - longint'(term);
      term = ((term * sq) >> 30) / 72;
      s    = s + longint'(term);
      term = ((term * sq) >> 30) / 110;
      s    = s - longint'(term);
      if (s < 0) s = 0;
      if (s > (longint'(1) << 30)) s = longint'(1) << 30;
      ss = longint'(s) * longint'(s) + (64'd1 << 43);
      return weight_type'(ss >> 44);
   endfunction

   // p + floor((r - p) * w / 2^16)
   function automatic corner_type lerp(corner_type p, corner_type r, weight_type w);
      logic signed [18:0] d;
      logic signed [36:0] prod;
      logic signed [18:0] step;
      d    = 19'(r) - 19'(p);
      prod = 37'(d) * 37'($signed({1'b0, w}));
      step = 19'(prod >>> 16);
      return corner_type'(19'(p) + step);
   endfunction

   weight_type cos_tbl [COS_TABLE_DEPTH];
   for (genvar i = 0; i < COS_TABLE_DEPTH; i++) begin : g_tbl
      assign cos_tbl[i] = cos_weight(i);
   end

   // ---- stage 1: lattice position, blend weights, hash pre-mix ----
   logic [Q_W-1:0]   qx_oct;
   logic [Q_W-1:0]   qy_oct;
   logic [31:0]      ix32;
   logic [31:0]      iy32;
   logic [31:0]      prod_x;
   logic [31:0]      prod_y;
   logic [TBL_W-1:0] idx_x;
   logic [TBL_W-1:0] idx_y;
   logic [31:0]      row0;
   logic [31:0]      row1;
   logic [31:0]      n_c [4];
   logic [31:0]      h_in [4];

   assign qx_oct = up_qx >> SHIFT;
   assign qy_oct = up_qy >> SHIFT;
   assign ix32   = 32'(qx_oct[Q_W-1:16]);
   assign iy32   = 32'(qy_oct[Q_W-1:16]);
   assign prod_x = 32'(qx_oct[15:0]) * 32'(COS_TABLE_DEPTH);
   assign prod_y = 32'(qy_oct[15:0]) * 32'(COS_TABLE_DEPTH);
   assign idx_x  = prod_x[TBL_W+15:16];
   assign idx_y  = prod_y[TBL_W+15:16];
   assign row0   = (cfg.seed_offset + iy32) * HASH_ROW_MUL;
   assign row1   = row0 + HASH_ROW_MUL;

   // corners: 0 = (x, y), 1 = (x+1, y), 2 = (x, y+1), 3 = (x+1, y+1)
   assign n_c[0] = ix32 + row0;
   assign n_c[1] = ix32 + 32'd1 + row0;
   assign n_c[2] = ix32 + row1;
   assign n_c[3] = ix32 + 32'd1 + row1;

   for (genvar c = 0; c < 4; c++) begin : g_mix
      assign h_in[c] = (n_c[c] << 13) ^ n_c[c];
   end

   logic [31:0] h1_ff [4];
   logic [31:0] h2_ff [4];
   logic [31:0] h3_ff [4];
   logic [31:0] sq2_ff [4];
   logic [31:0] t3_ff [4];
   logic [31:0] m_in [4];
   corner_type  c4_ff [4];
   weight_type  wx_ff [4];
   weight_type  wy_ff [5];
   corner_type  top5_ff;
   corner_type  bot5_ff;
   corner_type  nz6_ff;

   always_comb begin
      for (int c = 0; c < 4; c++) begin
         m_in[c] = h3_ff[c] * t3_ff[c] + HASH_ADD_B;
      end
   end

   always_ff @(posedge clock) begin
      for (int c = 0; c < 4; c++) begin
         h1_ff[c]  <= h_in[c];
         sq2_ff[c] <= h1_ff[c] * h1_ff[c];
         h2_ff[c]  <= h1_ff[c];
         t3_ff[c]  <= sq2_ff[c] * HASH_MUL_A + HASH_ADD_A;
         h3_ff[c]  <= h2_ff[c];
         c4_ff[c]  <= corner_type'({1'b0, UNITY}) - corner_type'({1'b0, m_in[c][30:14]});
      end
      wx_ff[0] <= cos_tbl[idx_x];
      wy_ff[0] <= cos_tbl[idx_y];
      for (int k = 1; k < 4; k++) wx_ff[k] <= wx_ff[k-1];
      for (int k = 1; k < 5; k++) wy_ff[k] <= wy_ff[k-1];
      top5_ff <= lerp(c4_ff[0], c4_ff[1], wx_ff[3]);
      bot5_ff <= lerp(c4_ff[2], c4_ff[3], wx_ff[3]);
      nz6_ff  <= lerp(top5_ff, bot5_ff, wy_ff[4]);
   end

   // ---- amplitude: persistence^(OCT+1), refreshed from the neighbor each cycle ----
   logic [31:0] amp_prod;
   amp_type     amp_ff;

   assign amp_prod = 32'(up_amp) * 32'(cfg.persistence);

   always_ff @(posedge clock) begin
      amp_ff <= (OCT == 0) ? cfg.persistence : amp_prod[31:16];
   end

   // ---- stage 7: scaled contribution added to the running sum ----
   logic signed [34:0] contrib_prod;
   sum_type            contrib;
   logic               active;
   sum_type            sum_in;

   assign contrib_prod = 35'(nz6_ff) * 35'($signed({1'b0, amp_ff}));
   assign contrib      = sum_type'(contrib_prod >>> 16);
   assign active       = ({29'd0, cfg.octave_count} >= 32'(OCT));

   logic                  vld_ff [STAGES];
   logic [Q_W-1:0]        qx_c_ff [STAGES];
   logic [Q_W-1:0]        qy_c_ff [STAGES];
   sum_type               sum_c_ff [STAGES];

   assign sum_in = active ? sum_c_ff[STAGES-2] + contrib : sum_c_ff[STAGES-2];

   always_ff @(posedge clock) begin
      qx_c_ff[0]  <= up_qx;
      qy_c_ff[0]  <= up_qy;
      sum_c_ff[0] <= up_sum;
      for (int k = 1; k < STAGES; k++) begin
         qx_c_ff[k] <= qx_c_ff[k-1];
         qy_c_ff[k] <= qy_c_ff[k-1];
      end
      for (int k = 1; k < STAGES - 1; k++) sum_c_ff[k] <= sum_c_ff[k-1];
      sum_c_ff[STAGES-1] <= sum_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < STAGES; k++) vld_ff[k] <= 1'b0;
      end else begin
         vld_ff[0] <= up_valid;
         for (int k = 1; k < STAGES; k++) vld_ff[k] <= vld_ff[k-1];
      end
   end

   assign dn_valid = vld_ff[STAGES-1];
   assign dn_qx    = qx_c_ff[STAGES-1];
   assign dn_qy    = qy_c_ff[STAGES-1];
   assign dn_sum   = sum_c_ff[STAGES-1];
   assign dn_amp   = amp_ff;

endmodule

[design/npx_checker.sv]
// Port-level checks for the value-noise height pixel block, bound to the top.
`timescale 1ns / 1ps
module npx_checker import npx_pkg::*; #(
   parameter int MAX_OCTAVES     = 8,
   parameter int COORD_BITS      = 12,
   parameter int COS_TABLE_DEPTH = 256
) (
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic        rsp_valid,
   input logic        psel,
   input logic        penable,
   input logic        pwrite,
   input logic [4:0]  paddr,
   input logic [31:0] pwdata,
   input logic [31:0] prdata,
   input logic        pready
);

   localparam int Q_W   = COORD_BITS + 16 + MAX_OCTAVES - 1;
   localparam int E_W   = (COORD_BITS + 3 > 15) ? COORD_BITS + 3 : 15;
   localparam int PEN_W = 2 * E_W + 15;
   localparam int DIV_W = (PEN_W > Q_W) ? PEN_W : Q_W;
   localparam int LAT   = 5 + DIV_W + 7 * MAX_OCTAVES;
   localparam int TBL_N = COS_TABLE_DEPTH;

   localparam logic [4:0] PERS_ADDR = {REG_PERSISTENCE, 2'b00};

   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##LAT rsp_valid)
      else $error("item accepted without a result %0d cycles later (table %0d)", LAT, TBL_N);

   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      !(start && !busy) |-> ##LAT !rsp_valid)
      else $error("result strobe without a matching item");

   a_readback: assert property (@(posedge clock) disable iff (reset)
      (psel && penable && pwrite && paddr == PERS_ADDR)
      |=> (paddr != PERS_ADDR) || (prdata[15:0] == $past(pwdata[15:0])))
      else $error("persistence register does not read back the written value");

   a_ready: assert property (@(posedge clock) disable iff (reset)
      psel |-> pready)
      else $error("register port stalled");

endmodule

bind value_noise_height_pixel npx_checker #(
   .MAX_OCTAVES(MAX_OCTAVES),
   .COORD_BITS(COORD_BITS),
   .COS_TABLE_DEPTH(COS_TABLE_DEPTH)
) u_npx_checker (
   .clock(clock), .reset(reset), .start(start), .busy(busy), .rsp_valid(rsp_valid),
   .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
   .pwdata(pwdata), .prdata(prdata), .pready(pready)
);
